// File: rtl/hl2coap_pkg.sv
// Package for the request-line to CoAP request encoder.
// Shared types, command/status structs and protocol constants; no dependencies.
package hl2coap_pkg;

  localparam int MAX_SEGMENT_DEF = 32;

  localparam logic [7:0] CHAR_P      = 8'h50;
  localparam logic [7:0] CHAR_O      = 8'h4f;
  localparam logic [7:0] CHAR_S      = 8'h53;
  localparam logic [7:0] CHAR_SLASH  = 8'h2f;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] COAP_HDR    = 8'h42;
  localparam logic [7:0] CODE_GET    = 8'h01;
  localparam logic [7:0] CODE_POST   = 8'h02;
  localparam logic [7:0] PAYLOAD_MRK = 8'hff;
  localparam logic [7:0] EXT_MIN     = 8'd13;
  localparam logic [4:0] OPT_HOST    = 5'd3;
  localparam logic [4:0] OPT_PATH    = 5'd11;
  localparam logic [4:0] OPT_BLOCK   = 5'd27;
  localparam logic [2:0] HDR_LAST    = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PREFIX,
    PH_URL,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  // What an accepted input beat turns into on the output side.
  typedef enum logic [2:0] {
    ACT_SILENT,
    ACT_HDR,
    ACT_SEG,
    ACT_PBYTE,
    ACT_PEND
  } act_t;

  // What follows the data bytes of an emitted segment.
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_END,
    TAIL_BLOCK
  } tail_t;

  typedef enum logic [3:0] {
    SEL_ONE,
    SEL_HDR,
    SEL_OHEAD,
    SEL_ODEXT,
    SEL_OLEXT,
    SEL_DATA,
    SEL_BHEAD,
    SEL_BDEXT,
    SEL_BZERO,
    SEL_BMARK
  } sel_t;

  typedef enum logic [3:0] {
    ST_IN,
    ST_ONE,
    ST_HDR,
    ST_OHEAD,
    ST_ODEXT,
    ST_OLEXT,
    ST_DATA,
    ST_BHEAD,
    ST_BDEXT,
    ST_BZERO,
    ST_BMARK
  } state_t;

  typedef struct packed {
    logic take;
    logic load;
    sel_t sel;
    logic last;
    logic ptr_inc;
  } cmd_t;

  typedef struct packed {
    act_t  act_in;
    tail_t tail;
    logic  slot_free;
    logic  seg_dext;
    logic  seg_lext;
    logic  blk_dext;
    logic  hdr_last;
    logic  data_last;
  } status_t;

endpackage

// File: rtl/hl2coap_ctrl.sv
// Sequencer of the encoder: accepts one line beat, then steps through its result beats.
// Depends on hl2coap_pkg for the state, command and status types.
module hl2coap_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 line_valid,
  output logic                 line_ready,
  input  hl2coap_pkg::status_t stat,
  output hl2coap_pkg::cmd_t    cmd
);
  import hl2coap_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IN: begin
        if (line_valid) begin
          unique case (stat.act_in)
            ACT_HDR: state_next = ST_HDR;
            ACT_SEG: state_next = ST_OHEAD;
            default: state_next = ST_ONE;
          endcase
        end
      end
      ST_ONE: if (stat.slot_free) state_next = ST_IN;
      ST_HDR: if (stat.slot_free && stat.hdr_last) state_next = ST_IN;
      ST_OHEAD: begin
        if (stat.slot_free) begin
          if (stat.seg_dext) state_next = ST_ODEXT;
          else if (stat.seg_lext) state_next = ST_OLEXT;
          else state_next = ST_DATA;
        end
      end
      ST_ODEXT: begin
        if (stat.slot_free) state_next = stat.seg_lext ? ST_OLEXT : ST_DATA;
      end
      ST_OLEXT: if (stat.slot_free) state_next = ST_DATA;
      ST_DATA: begin
        if (stat.slot_free && stat.data_last) begin
          state_next = (stat.tail == TAIL_BLOCK) ? ST_BHEAD : ST_IN;
        end
      end
      ST_BHEAD: begin
        if (stat.slot_free) state_next = stat.blk_dext ? ST_BDEXT : ST_BZERO;
      end
      ST_BDEXT: if (stat.slot_free) state_next = ST_BZERO;
      ST_BZERO: if (stat.slot_free) state_next = ST_BMARK;
      ST_BMARK: if (stat.slot_free) state_next = ST_IN;
      default: state_next = ST_IN;
    endcase
  end

  always_comb begin
    line_ready  = (state == ST_IN);
    cmd.take    = (state == ST_IN) && line_valid;
    cmd.load    = (state != ST_IN) && stat.slot_free;
    cmd.sel     = SEL_ONE;
    cmd.last    = 1'b0;
    cmd.ptr_inc = 1'b0;
    unique case (state)
      ST_IN:    cmd.sel = SEL_ONE;
      ST_ONE: begin
        cmd.sel  = SEL_ONE;
        cmd.last = 1'b1;
      end
      ST_HDR: begin
        cmd.sel     = SEL_HDR;
        cmd.last    = stat.hdr_last;
        cmd.ptr_inc = stat.slot_free && !stat.hdr_last;
      end
      ST_OHEAD: cmd.sel = SEL_OHEAD;
      ST_ODEXT: cmd.sel = SEL_ODEXT;
      ST_OLEXT: cmd.sel = SEL_OLEXT;
      ST_DATA: begin
        cmd.sel     = SEL_DATA;
        cmd.last    = stat.data_last && (stat.tail != TAIL_BLOCK);
        cmd.ptr_inc = stat.slot_free && !stat.data_last;
      end
      ST_BHEAD: cmd.sel = SEL_BHEAD;
      ST_BDEXT: cmd.sel = SEL_BDEXT;
      ST_BZERO: cmd.sel = SEL_BZERO;
      ST_BMARK: begin
        cmd.sel  = SEL_BMARK;
        cmd.last = 1'b1;
      end
      default: cmd.sel = SEL_ONE;
    endcase
  end

endmodule

// File: rtl/hl2coap_dp.sv
// Datapath of the encoder: request state, segment buffer, header/option byte mux
// and the output register. Depends on hl2coap_pkg; driven by hl2coap_ctrl.
module hl2coap_dp #(
  parameter int MAX_SEGMENT = hl2coap_pkg::MAX_SEGMENT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           in_byte,
  input  logic                 start_req,
  input  logic [15:0]          coap_mid,
  input  logic [15:0]          token,
  input  hl2coap_pkg::cmd_t    cmd,
  output hl2coap_pkg::status_t stat,
  output logic                 coap_valid,
  input  logic                 coap_ready,
  output logic [7:0]           out_byte,
  output logic                 out_valid,
  output logic                 run_last,
  output logic                 msg_end,
  output logic                 is_host,
  output logic                 overflow
);
  import hl2coap_pkg::*;

  localparam int LEN_W = $clog2(MAX_SEGMENT + 2);
  localparam int IDX_W = (MAX_SEGMENT > 1) ? $clog2(MAX_SEGMENT) : 1;
  localparam int PTR_W = (IDX_W > 3) ? IDX_W : 3;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SEGMENT);
  localparam logic [LEN_W-1:0] OVF_LEN = LEN_W'(MAX_SEGMENT + 1);

  function automatic logic [3:0] nib(input logic [7:0] v);
    nib = (v < EXT_MIN) ? v[3:0] : EXT_MIN[3:0];
  endfunction

  // request state
  phase_t            phase;
  logic              is_post;
  logic [2:0]        prefix_count;
  logic [LEN_W-1:0]  segment_length;
  logic              host_done;
  logic [4:0]        last_option;
  logic [31:0]       saved_ids;

  // per-beat latched work
  act_t              act;
  tail_t             tail;
  logic [LEN_W-1:0]  seg_len;
  logic              seg_ovf;
  logic [4:0]        seg_delta;
  logic              seg_host;
  logic [4:0]        blk_delta;
  logic [7:0]        item_byte;

  logic [PTR_W-1:0]  ptr;
  logic [PTR_W-1:0]  ptr_next;
  logic [7:0]        rd_data;
  logic [7:0]        mem [MAX_SEGMENT];

  // decode of the offered line beat
  phase_t            eff_phase;
  logic              eff_post;
  logic [2:0]        eff_pc;
  logic [LEN_W-1:0]  eff_sl;
  logic              eff_hd;
  logic [4:0]        eff_lo;
  phase_t            phase_next;
  logic              is_post_next;
  logic [2:0]        prefix_count_next;
  logic [LEN_W-1:0]  segment_length_next;
  logic              host_done_next;
  logic [4:0]        last_option_next;
  act_t              act_in;
  tail_t             tail_in;
  logic              do_append;
  logic              wr_en;
  logic [4:0]        opt;
  logic [LEN_W-1:0]  seg_len_in;
  logic              is_delim;

  logic [7:0]        byte_mux;
  logic              valid_mux;
  logic              host_mux;
  logic              ovf_mux;
  logic              end_mux;

  always_comb begin
    eff_phase = start_req ? PH_PREFIX : phase;
    eff_post  = start_req ? 1'b0 : is_post;
    eff_pc    = start_req ? 3'd0 : prefix_count;
    eff_sl    = start_req ? '0 : segment_length;
    eff_hd    = start_req ? 1'b0 : host_done;
    eff_lo    = start_req ? 5'd0 : last_option;

    phase_next          = eff_phase;
    is_post_next        = eff_post;
    prefix_count_next   = eff_pc;
    segment_length_next = eff_sl;
    host_done_next      = eff_hd;
    last_option_next    = eff_lo;
    act_in              = ACT_SILENT;
    tail_in             = TAIL_NONE;
    do_append           = 1'b0;
    wr_en               = 1'b0;
    opt                 = eff_hd ? OPT_PATH : OPT_HOST;
    seg_len_in          = (eff_sl > MAX_LEN) ? MAX_LEN : eff_sl;
    is_delim            = (in_byte == CHAR_SLASH) || (in_byte == CHAR_SPACE);

    unique case (eff_phase)
      PH_PREFIX: begin
        if (eff_pc == 3'd0) begin
          is_post_next = (in_byte == CHAR_P);
        end else if (eff_pc == 3'd1) begin
          is_post_next = eff_post && (in_byte == CHAR_O);
        end else if (eff_pc == 3'd2) begin
          is_post_next = eff_post && (in_byte == CHAR_S);
          act_in       = ACT_HDR;
        end
        prefix_count_next = eff_pc + 3'd1;
        if (prefix_count_next >= (is_post_next ? 3'd5 : 3'd4)) phase_next = PH_URL;
      end
      PH_URL: begin
        if (eff_sl == '0) begin
          do_append = 1'b1;
        end else if (is_delim) begin
          act_in              = ACT_SEG;
          host_done_next      = 1'b1;
          last_option_next    = opt;
          segment_length_next = '0;
          if (in_byte == CHAR_SPACE) begin
            if (eff_post) begin
              tail_in          = TAIL_BLOCK;
              last_option_next = OPT_BLOCK;
              phase_next       = PH_PAYLOAD;
            end else begin
              tail_in    = TAIL_END;
              phase_next = PH_DONE;
            end
          end
        end else begin
          do_append = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        if (in_byte == CHAR_SPACE) begin
          act_in     = ACT_PEND;
          phase_next = PH_DONE;
        end else begin
          act_in = ACT_PBYTE;
        end
      end
      PH_IDLE, PH_DONE: ;
      default: ;
    endcase

    // past the buffer, mark the segment as overlong and drop the byte
    if (do_append) begin
      if (eff_sl < MAX_LEN) begin
        wr_en               = 1'b1;
        segment_length_next = eff_sl + 1'b1;
      end else begin
        segment_length_next = OVF_LEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      is_post        <= 1'b0;
      prefix_count   <= 3'd0;
      segment_length <= '0;
      host_done      <= 1'b0;
      last_option    <= 5'd0;
      saved_ids      <= 32'd0;
      act            <= ACT_SILENT;
      tail           <= TAIL_NONE;
      ptr            <= '0;
      coap_valid     <= 1'b0;
    end else begin
      if (cmd.take) begin
        phase          <= phase_next;
        is_post        <= is_post_next;
        prefix_count   <= prefix_count_next;
        segment_length <= segment_length_next;
        host_done      <= host_done_next;
        last_option    <= last_option_next;
        act            <= act_in;
        tail           <= tail_in;
        if (start_req) saved_ids <= {coap_mid, token};
      end
      ptr <= ptr_next;
      if (cmd.load) begin
        coap_valid <= 1'b1;
      end else if (coap_ready) begin
        coap_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      seg_len   <= seg_len_in;
      seg_ovf   <= (eff_sl > MAX_LEN);
      seg_delta <= opt - eff_lo;
      seg_host  <= !eff_hd;
      blk_delta <= OPT_BLOCK - opt;
      item_byte <= in_byte;
    end
    if (cmd.load) begin
      out_byte  <= byte_mux;
      out_valid <= valid_mux;
      run_last  <= cmd.last;
      msg_end   <= end_mux;
      is_host   <= host_mux;
      overflow  <= ovf_mux;
    end
  end

  // segment buffer: write on append, registered read at the next pointer
  always_ff @(posedge clk) begin
    if (cmd.take && wr_en) mem[eff_sl[IDX_W-1:0]] <= in_byte;
    rd_data <= mem[ptr_next[IDX_W-1:0]];
  end

  always_comb begin
    if (cmd.take) ptr_next = '0;
    else if (cmd.ptr_inc) ptr_next = ptr + 1'b1;
    else ptr_next = ptr;
  end

  always_comb begin
    byte_mux  = 8'd0;
    valid_mux = 1'b1;
    host_mux  = 1'b0;
    ovf_mux   = 1'b0;
    end_mux   = 1'b0;
    unique case (cmd.sel)
      SEL_ONE: begin
        if (act == ACT_PBYTE) begin
          byte_mux = item_byte;
        end else begin
          valid_mux = 1'b0;
          end_mux   = (act == ACT_PEND);
        end
      end
      SEL_HDR: begin
        unique case (ptr[2:0])
          3'd0:    byte_mux = COAP_HDR;
          3'd1:    byte_mux = is_post ? CODE_POST : CODE_GET;
          3'd2:    byte_mux = saved_ids[31:24];
          3'd3:    byte_mux = saved_ids[23:16];
          3'd4:    byte_mux = saved_ids[15:8];
          3'd5:    byte_mux = saved_ids[7:0];
          default: byte_mux = 8'd0;
        endcase
      end
      SEL_OHEAD: begin
        byte_mux = {nib(8'(seg_delta)), nib(8'(seg_len))};
        ovf_mux  = seg_ovf;
      end
      SEL_ODEXT: begin
        byte_mux = 8'(seg_delta) - EXT_MIN;
        ovf_mux  = seg_ovf;
      end
      SEL_OLEXT: begin
        byte_mux = 8'(seg_len) - EXT_MIN;
        ovf_mux  = seg_ovf;
      end
      SEL_DATA: begin
        byte_mux = rd_data;
        host_mux = seg_host;
        ovf_mux  = seg_ovf;
        end_mux  = stat.data_last && (tail == TAIL_END);
      end
      SEL_BHEAD: byte_mux = {nib(8'(blk_delta)), 4'd1};
      SEL_BDEXT: byte_mux = 8'(blk_delta) - EXT_MIN;
      SEL_BZERO: byte_mux = 8'd0;
      SEL_BMARK: byte_mux = PAYLOAD_MRK;
      default: begin
        byte_mux  = 8'd0;
        valid_mux = 1'b0;
      end
    endcase
  end

  always_comb begin
    stat.act_in    = act_in;
    stat.tail      = tail;
    stat.slot_free = !coap_valid || coap_ready;
    stat.seg_dext  = (8'(seg_delta) >= EXT_MIN);
    stat.seg_lext  = (8'(seg_len) >= EXT_MIN);
    stat.blk_dext  = (8'(blk_delta) >= EXT_MIN);
    stat.hdr_last  = (ptr[2:0] == HDR_LAST);
    stat.data_last = (8'(ptr) == (8'(seg_len) - 8'd1));
  end

endmodule

// File: rtl/http_line_to_coap_request.sv
// Top level of the request-line to CoAP request encoder.
// Depends on hl2coap_pkg, hl2coap_ctrl and hl2coap_dp.
//
//   channel  | handshake               | beat payload
//   ---------+-------------------------+---------------------------------------------
//   line     | line_valid / line_ready | in_byte, start_req, coap_mid, token
//   coap     | coap_valid / coap_ready | out_byte, out_valid, run_last, msg_end,
//            |                         | is_host, overflow
//
// A line beat is accepted while the sequencer waits for input; its result beats then
// follow one per cycle unless coap stalls, and no new line beat is taken before the
// last: one result for a buffered or silent byte, up to 38 at a segment end. The
// sequencer and the buffer (one byte per cycle, registered read) set this pace.
// Synchronous reset returns to idle awaiting start; the buffer is not cleared.
// A stall on coap holds the output register and the sequencer in place.
module http_line_to_coap_request #(
  parameter int MAX_SEGMENT = hl2coap_pkg::MAX_SEGMENT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // line channel
  input  logic        line_valid,
  output logic        line_ready,
  input  logic [7:0]  in_byte,
  input  logic        start_req,
  input  logic [15:0] coap_mid,
  input  logic [15:0] token,
  // coap channel
  output logic        coap_valid,
  input  logic        coap_ready,
  output logic [7:0]  out_byte,
  output logic        out_valid,
  output logic        run_last,
  output logic        msg_end,
  output logic        is_host,
  output logic        overflow
);
  import hl2coap_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t stat;

  // Sequencer: take a line beat, then walk header, option head, extension
  // bytes, buffered data and the Block1 tail as the decoded beat asks.
  hl2coap_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .line_valid (line_valid),
    .line_ready (line_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: method detection, segment buffering, option numbering, the
  // output byte mux and the output register that decouples the coap side.
  hl2coap_dp #(
    .MAX_SEGMENT (MAX_SEGMENT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (in_byte),
    .start_req  (start_req),
    .coap_mid   (coap_mid),
    .token      (token),
    .cmd        (cmd),
    .stat       (stat),
    .coap_valid (coap_valid),
    .coap_ready (coap_ready),
    .out_byte   (out_byte),
    .out_valid  (out_valid),
    .run_last   (run_last),
    .msg_end    (msg_end),
    .is_host    (is_host),
    .overflow   (overflow)
  );

endmodule
